### rtl/core/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg: shared definitions for the sorted lists merge median unit
// Sizes, operation codes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  // Capacity of each list and the widths that follow from it.
  localparam int LIST_DEPTH = 256;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int TOT_W      = CNT_W + 1;

  // Payload widths.
  localparam int VAL_W      = 32;
  localparam int RES_W      = VAL_W + 1;
  localparam int OUT_DATA_W = 40;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_PUSH_A = 2'd0;
  localparam logic [1:0] OP_PUSH_B = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push_a;  // append the input value to the first list
    logic push_b;  // append the input value to the second list
    logic start;   // rewind the merge cursors
    logic step;    // take one element of the merge walk
    logic finish;  // load the result register and clear the lists
  } smm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic total_zero;  // both lists are empty
    logic walk_last;   // the current step reaches the middle of the walk
    logic out_free;    // the result register can take a new result
  } smm_stat_t;

endpackage

`default_nettype wire

### rtl/core/smm_datapath.sv
// ----------------------------------------------------------------------------
// smm_datapath: list storage, merge walk and result register
// Holds both lists in memories with registered reads, walks them one element
// per cycle and forms twice the median in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire smm_pkg::smm_cmd_t           cmd,
  output smm_pkg::smm_stat_t               stat,
  input  wire logic [smm_pkg::VAL_W-1:0]   in_value,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [smm_pkg::RES_W-1:0]        out_median,
  output logic                             out_empty,
  output logic                             out_ovf
);

  logic [smm_pkg::VAL_W-1:0]  mem_a [smm_pkg::LIST_DEPTH];
  logic [smm_pkg::VAL_W-1:0]  mem_b [smm_pkg::LIST_DEPTH];
  logic [smm_pkg::VAL_W-1:0]  rd_a_r;
  logic [smm_pkg::VAL_W-1:0]  rd_b_r;

  logic [smm_pkg::CNT_W-1:0]  cnt_a_r, cnt_a_nxt;
  logic [smm_pkg::CNT_W-1:0]  cnt_b_r, cnt_b_nxt;
  logic                       drop_r, drop_nxt;
  logic [smm_pkg::CNT_W-1:0]  p_a_r, p_a_nxt;
  logic [smm_pkg::CNT_W-1:0]  p_b_r, p_b_nxt;
  logic [smm_pkg::CNT_W-1:0]  k_r, k_nxt;
  logic [smm_pkg::VAL_W-1:0]  cur_r, cur_nxt;
  logic [smm_pkg::VAL_W-1:0]  prev_r, prev_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [smm_pkg::RES_W-1:0]  med_r;
  logic                       empty_r;
  logic                       ovf_r;

  logic [smm_pkg::TOT_W-1:0]  total;
  logic                       full_a, full_b;
  logic                       we_a, we_b;
  logic                       avail_a, avail_b;
  logic                       take_a, use_a, use_b;
  logic [smm_pkg::VAL_W-1:0]  pick;
  logic [smm_pkg::RES_W-1:0]  doubled;

  // Element counts and the total over both lists.
  assign total  = {1'b0, cnt_a_r} + {1'b0, cnt_b_r};
  assign full_a = (cnt_a_r == smm_pkg::CNT_W'(smm_pkg::LIST_DEPTH));
  assign full_b = (cnt_b_r == smm_pkg::CNT_W'(smm_pkg::LIST_DEPTH));
  assign we_a   = cmd.push_a && !full_a;
  assign we_b   = cmd.push_b && !full_b;

  // Merge decision on the two heads; ties go to the first list.
  always_comb begin
    avail_a = (p_a_r < cnt_a_r);
    avail_b = (p_b_r < cnt_b_r);
    if (!avail_b) begin
      take_a = 1'b1;
    end else if (!avail_a) begin
      take_a = 1'b0;
    end else begin
      take_a = ($signed(rd_a_r) <= $signed(rd_b_r));
    end
    use_a = take_a && avail_a;
    use_b = !use_a && avail_b;
    if (use_a) begin
      pick = rd_a_r;
    end else if (use_b) begin
      pick = rd_b_r;
    end else begin
      pick = '0;
    end
  end

  // Cursor, step count and the last two walked elements.
  always_comb begin
    p_a_nxt  = p_a_r;
    p_b_nxt  = p_b_r;
    k_nxt    = k_r;
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    if (cmd.start) begin
      p_a_nxt  = '0;
      p_b_nxt  = '0;
      k_nxt    = '0;
      cur_nxt  = '0;
      prev_nxt = '0;
    end else if (cmd.step) begin
      p_a_nxt  = p_a_r + smm_pkg::CNT_W'(use_a);
      p_b_nxt  = p_b_r + smm_pkg::CNT_W'(use_b);
      k_nxt    = k_r + 1'b1;
      cur_nxt  = pick;
      prev_nxt = cur_r;
    end
  end

  // Twice the median: double the middle element or add the middle pair; zero when both lists are empty.
  always_comb begin
    if (total == '0) begin
      doubled = '0;
    end else if (total[0]) begin
      doubled = {cur_r, 1'b0};
    end else begin
      doubled = {cur_r[smm_pkg::VAL_W-1], cur_r} + {prev_r[smm_pkg::VAL_W-1], prev_r};
    end
  end

  // Counts and the drop flag, cleared when a result is loaded.
  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    drop_nxt  = drop_r;
    if (cmd.finish) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      drop_nxt  = 1'b0;
    end else begin
      if (we_a) begin
        cnt_a_nxt = cnt_a_r + 1'b1;
      end
      if (we_b) begin
        cnt_b_nxt = cnt_b_r + 1'b1;
      end
      if ((cmd.push_a && full_a) || (cmd.push_b && full_b)) begin
        drop_nxt = 1'b1;
      end
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // List memories; the read address follows the next cursor value so the
  // registered head matches the cursor in every cycle of the walk.
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[cnt_a_r[smm_pkg::ADDR_W-1:0]] <= in_value;
    end
    rd_a_r <= mem_a[p_a_nxt[smm_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[cnt_b_r[smm_pkg::ADDR_W-1:0]] <= in_value;
    end
    rd_b_r <= mem_b[p_b_nxt[smm_pkg::ADDR_W-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      drop_r      <= 1'b0;
      p_a_r       <= '0;
      p_b_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      drop_r      <= drop_nxt;
      p_a_r       <= p_a_nxt;
      p_b_r       <= p_b_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    if (cmd.finish) begin
      med_r   <= doubled;
      empty_r <= (total == '0);
      ovf_r   <= drop_r;
    end
  end

  // Status back to the controller.
  assign stat.total_zero = (total == '0);
  assign stat.walk_last  = (k_r == total[smm_pkg::TOT_W-1:1]);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_median = med_r;
  assign out_empty  = empty_r;
  assign out_ovf    = ovf_r;

endmodule

`default_nettype wire

### rtl/core/smm_ctrl.sv
// ----------------------------------------------------------------------------
// smm_ctrl: sequencing of pushes, the merge walk and result delivery
// Accepts items while idle, runs the walk after a finish when the lists
// hold elements, and hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_op,
  output logic                     in_ready,
  input  wire smm_pkg::smm_stat_t  stat,
  output smm_pkg::smm_cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            smm_pkg::OP_PUSH_A: cmd.push_a = 1'b1;
            smm_pkg::OP_PUSH_B: cmd.push_b = 1'b1;
            smm_pkg::OP_FINISH: begin
              cmd.start = 1'b1;
              state_nxt = stat.total_zero ? ST_DONE : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sorted_lists_merge_median_unit.sv
// ----------------------------------------------------------------------------
// sorted_lists_merge_median_unit: median of two ascending lists
// Pushes build two lists of signed 32-bit values; a finish item merges them
// and returns twice the median with empty and overflow flags.
// ----------------------------------------------------------------------------
// A push item is accepted while the unit is idle, and pushes stream in at
// one per cycle while it stays idle. A finish item rewinds the merge cursors
// in the cycle that accepts it. It then holds in_tready low through the
// walk, one merge step per cycle over total/2 + 1 elements, where total is
// the number of stored elements, and through the load of the result. A
// finish on two empty lists skips the walk and holds in_tready low only for
// the load. The load waits while an earlier result is still held on the
// output, so a stalled out_tready lengthens the stall. The result is
// presented on the cycle after the load. The walk rate is set by the
// compare-and-advance step on the registered read ports of the two list
// memories. Each list holds 256 values; a push to a full list is dropped
// and reported in the overflow flag of the next result. The list memories
// need no clearing pass after reset.
`default_nettype none

module sorted_lists_merge_median_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [32:0] median_doubled, [39:33] zero
  output logic [1:0]       out_tuser   // [0] empty_error, [1] overflow
);

  smm_pkg::smm_cmd_t           cmd;
  smm_pkg::smm_stat_t          stat;
  logic [smm_pkg::RES_W-1:0]   median;
  logic                        empty_flag;
  logic                        ovf_flag;

  smm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (in_tdata),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_median (median),
    .out_empty  (empty_flag),
    .out_ovf    (ovf_flag)
  );

  // Pack the result item.
  assign out_tdata = {(smm_pkg::OUT_DATA_W - smm_pkg::RES_W)'(0), median};
  assign out_tuser = {ovf_flag, empty_flag};

  // A finish item stops intake until its result has been loaded.
  a_finish_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == smm_pkg::OP_FINISH) |=> !in_tready)
    else $error("input accepted right after a finish item");

  // An empty finish reports a zero median.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[32:0] == 33'd0))
    else $error("empty result carries a nonzero median");

  // A new result only appears from the load cycle, when intake is stalled.
  a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared outside the load cycle");

endmodule

`default_nettype wire

### dv/tb_sorted_lists_merge_median_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_lists_merge_median_unit: testbench for the merge median unit
// Pushes build two lists and a finish item asks for twice their median. A
// short directed table covers the extremes, ties, unordered lists, ignored
// operations and empty finishes; randomized list pairs follow, mostly sorted,
// at least two filled past capacity. Results are checked against an in-bench
// merge walk model or a typed row's result while both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_lists_merge_median_unit;

  // The one operation code that the block ignores.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam int DIR_ROWS     = 25;
  localparam int ITEM_TARGET  = 1250;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic signed [smm_pkg::RES_W-1:0] median_doubled;
    logic                             empty_error;
    logic                             overflow;
  } median_result_t;

  // One row of directed stimulus; typed rows carry a fixed expected result.
  typedef struct packed {
    logic [1:0]     op;
    logic [31:0]    value;
    logic           typed;
    median_result_t res;
  } stim_row_t;

  localparam median_result_t NO_RES    = '0;
  localparam median_result_t RES_EMPTY = '{median_doubled: '0, empty_error: 1'b1,
                                           overflow: 1'b0};
  localparam median_result_t RES_MAX   = '{median_doubled: 33'h0_FFFF_FFFE,
                                           empty_error: 1'b0, overflow: 1'b0};
  localparam median_result_t RES_MIN   = '{median_doubled: 33'h1_0000_0000,
                                           empty_error: 1'b0, overflow: 1'b0};
  localparam median_result_t RES_NEG1  = '{median_doubled: 33'h1_FFFF_FFFF,
                                           empty_error: 1'b0, overflow: 1'b0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  // Travels with each driven item so the monitor knows a typed expectation.
  logic           drv_typed = 1'b0;
  median_result_t drv_res = '0;

  // Shadow copy of the block's lists.
  logic signed [smm_pkg::VAL_W-1:0] shadow_a [smm_pkg::LIST_DEPTH];
  logic signed [smm_pkg::VAL_W-1:0] shadow_b [smm_pkg::LIST_DEPTH];
  int  count_a = 0;
  int  count_b = 0;
  bit  dropped = 1'b0;

  median_result_t expected_medians [$];
  stim_row_t      directed_rows [DIR_ROWS];
  int  fail_count = 0;
  int  item_count = 0;
  bit  in_burst = 1'b0;
  bit  out_burst = 1'b0;

  sorted_lists_merge_median_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] value
    .in_tuser   (in_tuser),   // [1:0] operation
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [32:0] median_doubled, [39:33] zero
    .out_tuser  (out_tuser)   // [0] empty_error, [1] overflow
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Walk both lists from the front up to the middle and return twice the
  // median; on a tie the first list's element is taken.
  function automatic median_result_t merge_median();
    median_result_t res;
    int total;
    int ia;
    int ib;
    bit take_a;
    longint prev;
    longint cur;
    longint doubled;
    total = count_a + count_b;
    ia = 0;
    ib = 0;
    prev = 0;
    cur = 0;
    doubled = 0;
    if (total != 0) begin
      for (int k = 0; k <= total / 2; k++) begin
        prev = cur;
        take_a = (ib >= count_b) || (ia < count_a && shadow_a[ia] <= shadow_b[ib]);
        if (take_a) begin
          cur = longint'(shadow_a[ia]);
          ia++;
        end else begin
          cur = longint'(shadow_b[ib]);
          ib++;
        end
      end
      doubled = (total % 2 != 0) ? cur * 2 : cur + prev;
    end
    res.median_doubled = doubled[smm_pkg::RES_W-1:0];
    res.empty_error = (total == 0);
    res.overflow = dropped;
    return res;
  endfunction

  // Update the shadow lists for one accepted item; a finish yields a result.
  function automatic void apply_item(logic [1:0] op, logic [31:0] val, logic typed,
                                     median_result_t typed_res);
    median_result_t res;
    case (op)
      smm_pkg::OP_PUSH_A: begin
        if (count_a < smm_pkg::LIST_DEPTH) begin
          shadow_a[count_a] = val;
          count_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      smm_pkg::OP_PUSH_B: begin
        if (count_b < smm_pkg::LIST_DEPTH) begin
          shadow_b[count_b] = val;
          count_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      smm_pkg::OP_FINISH: begin
        res = merge_median();
        expected_medians.push_back(typed ? typed_res : res);
        count_a = 0;
        count_b = 0;
        dropped = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Input monitor: every accepted item goes through the model.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      apply_item(in_tuser, in_tdata, drv_typed, drv_res);
    end
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    median_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_medians.size() == 0) begin
        $error("result item with no expected result waiting: tdata %h tuser %b",
               out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_medians.pop_front();
        if ($signed(out_tdata[32:0]) != want.median_doubled) begin
          $error("median_doubled: expected %0d, actual %0d", want.median_doubled,
                 $signed(out_tdata[32:0]));
          fail_count++;
        end
        if (out_tdata[39:33] != '0) begin
          $error("tdata padding: expected 0, actual %h", out_tdata[39:33]);
          fail_count++;
        end
        if (out_tuser[0] != want.empty_error) begin
          $error("empty_error: expected %0b, actual %0b", want.empty_error, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] != want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  // Result side: random stalls per item, with stretches of none.
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) out_burst = ~out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Drive one item after a random gap and hold it until it is accepted.
  task automatic send_item(logic [1:0] op, logic [31:0] val, logic typed,
                           median_result_t typed_res);
    int gap;
    if ($urandom_range(0, 29) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= val;
    drv_typed <= typed;
    drv_res <= typed_res;
    do @(posedge clk); while (!in_tready);
    item_count++;
  endtask

  // Value pools: full range, a narrow band full of ties, and the extremes.
  function automatic logic [31:0] draw_value(int vmode);
    case (vmode)
      0: return $urandom;
      1: return 32'($urandom_range(0, 8)) - 32'd4;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - 32'($urandom_range(0, 3))
                                     : 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: return draw_value($urandom_range(0, 2));
    endcase
  endfunction

  // Build two lists, sorted if asked, push them interleaved at random, then finish if asked.
  task automatic run_list_pair(int n_a, int n_b, int vmode, bit sorted_lists,
                               bit with_finish);
    int qa [$];
    int qb [$];
    int ia;
    int ib;
    bit pick_a;
    for (int i = 0; i < n_a; i++) qa.push_back(int'(draw_value(vmode)));
    for (int i = 0; i < n_b; i++) qb.push_back(int'(draw_value(vmode)));
    if (sorted_lists) begin
      qa.sort();
      qb.sort();
    end
    ia = 0;
    ib = 0;
    while (ia < n_a || ib < n_b) begin
      if ($urandom_range(0, 19) == 0) send_item(OP_IGNORED, $urandom, 1'b0, NO_RES);
      pick_a = (ib >= n_b) || (ia < n_a && $urandom_range(0, 1) == 1);
      if (pick_a) begin
        send_item(smm_pkg::OP_PUSH_A, qa[ia], 1'b0, NO_RES);
        ia++;
      end else begin
        send_item(smm_pkg::OP_PUSH_B, qb[ib], 1'b0, NO_RES);
        ib++;
      end
    end
    if (with_finish) send_item(smm_pkg::OP_FINISH, $urandom, 1'b0, NO_RES);
  endtask

  // Main sequence: reset, directed table, list pairs, drain and verdict.
  initial begin
    int r;
    int n_a;
    int n_b;
    directed_rows = '{
      '{smm_pkg::OP_FINISH, 32'h0000_0000, 1'b1, RES_EMPTY},
      '{smm_pkg::OP_PUSH_A, 32'h7FFF_FFFF, 1'b0, NO_RES},
      '{smm_pkg::OP_FINISH, 32'hFFFF_FFFF, 1'b1, RES_MAX},
      '{smm_pkg::OP_PUSH_B, 32'h8000_0000, 1'b0, NO_RES},
      '{smm_pkg::OP_FINISH, 32'h0000_0000, 1'b1, RES_MIN},
      '{smm_pkg::OP_PUSH_A, 32'h7FFF_FFFF, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_B, 32'h7FFF_FFFF, 1'b0, NO_RES},
      '{smm_pkg::OP_FINISH, 32'h0000_0000, 1'b1, RES_MAX},
      '{smm_pkg::OP_PUSH_A, 32'h8000_0000, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_B, 32'h8000_0000, 1'b0, NO_RES},
      '{smm_pkg::OP_FINISH, 32'h0000_0000, 1'b1, RES_MIN},
      '{smm_pkg::OP_PUSH_A, 32'h8000_0000, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_B, 32'h7FFF_FFFF, 1'b0, NO_RES},
      '{smm_pkg::OP_FINISH, 32'h0000_0000, 1'b1, RES_NEG1},
      '{OP_IGNORED,         32'hFFFF_FFFF, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_A, 32'h0000_0005, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_B, 32'h0000_0005, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_B, 32'h0000_0009, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_A, 32'h0000_0001, 1'b0, NO_RES},
      '{smm_pkg::OP_FINISH, 32'h0000_0000, 1'b0, NO_RES},
      '{smm_pkg::OP_FINISH, 32'h5555_AAAA, 1'b1, RES_EMPTY},
      '{smm_pkg::OP_PUSH_A, 32'hFFFF_FFFD, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_B, 32'h0000_0004, 1'b0, NO_RES},
      '{smm_pkg::OP_PUSH_A, 32'h0000_000A, 1'b0, NO_RES},
      '{smm_pkg::OP_FINISH, 32'h0000_0000, 1'b0, NO_RES}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].res);
    end

    // Overfill each list once so both drop paths reach the overflow flag.
    run_list_pair(258, 3, 0, 1'b1, 1'b1);
    run_list_pair(2, 257, 3, 1'b1, 1'b1);

    while (item_count < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_item(smm_pkg::OP_FINISH, $urandom, 1'b0, NO_RES);
      end else begin
        if (r < 5) begin
          n_a = $urandom_range(200, 260);
          n_b = $urandom_range(0, 260);
        end else if (r < 20) begin
          n_a = $urandom_range(0, 40);
          n_b = $urandom_range(0, 40);
        end else begin
          n_a = $urandom_range(0, 12);
          n_b = $urandom_range(0, 12);
        end
        // Mostly sorted lists; a few unordered ones and a few runs that
        // carry over into the next one without a finish.
        run_list_pair(n_a, n_b, $urandom_range(0, 3), $urandom_range(0, 9) != 0,
                      $urandom_range(0, 19) != 0);
      end
    end
    send_item(smm_pkg::OP_FINISH, $urandom, 1'b0, NO_RES);
    in_tvalid <= 1'b0;

    while (expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_medians.size() != 0) begin
      $error("%0d expected results never arrived", expected_medians.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
